[sv/arblm_pkg.sv]
package arblm_pkg;

  // fixed field widths
  localparam int unsigned CFG_W      = 18;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned LIT_W      = 4;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned QUOT_W     = 8;
  localparam int unsigned OUT_PAD_W  = 3;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned THR_W      = CFG_W + 1;
  localparam int unsigned HUE_MOD    = 255;

  // reset values of the configuration registers
  localparam logic [CFG_W-1:0]   RST_BASELINE   = 18'd0;
  localparam logic [CFG_W-1:0]   RST_MARGIN     = 18'd120;
  localparam logic               RST_HUE_SRC    = 1'b1;
  localparam logic [COLOR_W-1:0] RST_FIXED_HUE  = 8'd250;
  localparam logic [COLOR_W-1:0] RST_SATURATION = 8'd220;
  localparam logic [COLOR_W-1:0] RST_BRIGHTNESS = 8'd60;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASELINE   = 3'd0,
    CFG_MARGIN     = 3'd1,
    CFG_HUE_SRC    = 3'd2,
    CFG_FIXED_HUE  = 3'd3,
    CFG_SATURATION = 3'd4,
    CFG_BRIGHTNESS = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0]   baseline;
    logic [CFG_W-1:0]   margin;
    logic               hue_from_sample;
    logic [COLOR_W-1:0] fixed_hue;
    logic [COLOR_W-1:0] saturation;
    logic [COLOR_W-1:0] brightness;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MUL,
    ST_DIV_LD,
    ST_DIV,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic mul;
    logic div_ld;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic div_last;
    logic out_free;
  } dp_sts_t;

  typedef struct packed {
    logic [COLOR_W-1:0] brightness;
    logic [COLOR_W-1:0] saturation;
    logic [COLOR_W-1:0] hue;
    logic               present;
    logic [LIT_W-1:0]   lit_count;
  } result_t;

endpackage

[sv/arblm_div.sv]
module arblm_div import arblm_pkg::*; #(
  parameter int unsigned NUM_W = 26,
  parameter int unsigned DEN_W = 18
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              init_i,
  input  logic              step_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic [QUOT_W-1:0] quot_o,
  output logic              last_o
);

  localparam int unsigned KW = $clog2(QUOT_W);

  logic [NUM_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [KW-1:0]     k_q, k_d;
  logic [NUM_W-1:0]  shifted;
  logic              fits;

  // restoring division, one quotient bit per step, msb first
  assign shifted = NUM_W'(den_q) << k_q;
  assign fits    = rem_q >= shifted;

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    k_d    = k_q;
    if (init_i) begin
      rem_d  = num_i;
      quot_d = '0;
      k_d    = KW'(QUOT_W - 1);
    end else if (step_i) begin
      if (fits) begin
        rem_d = rem_q - shifted;
      end
      quot_d = {quot_q[QUOT_W-2:0], fits};
      k_d    = k_q - KW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else begin
      k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (init_i) begin
      den_q <= den_i;
    end
  end

  assign quot_o = quot_q;
  assign last_o = k_q == '0;

endmodule

[sv/arblm_datapath.sv]
module arblm_datapath import arblm_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 24,
  parameter int unsigned BAR_LENGTH   = 12,
  parameter int unsigned SAMPLE_BITS  = 18
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  output dp_sts_t                sts_o,
  input  cfg_t                   cfg_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output result_t                result_o
);

  localparam int unsigned AW   = $clog2(WINDOW_DEPTH);
  localparam int unsigned FW   = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned PW   = SAMPLE_BITS + QUOT_W;
  localparam int unsigned TW   = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);
  localparam logic [FW-1:0] FULL      = FW'(WINDOW_DEPTH);

  function automatic logic [COLOR_W-1:0] mod255(input logic [SAMPLE_BITS-1:0] v);
    logic [31:0] w;
    logic [9:0]  s;
    logic [8:0]  f;
    w = 32'(v);
    // 256 is 1 modulo 255, so bytes fold by plain addition
    s = 10'(w[7:0]) + 10'(w[15:8]) + 10'(w[23:16]) + 10'(w[31:24]);
    f = 9'(s[7:0]) + 9'(s[9:8]);
    if (f >= 9'(HUE_MOD)) begin
      f = f - 9'(HUE_MOD);
    end
    return f[COLOR_W-1:0];
  endfunction

  logic [SAMPLE_BITS-1:0] mem [WINDOW_DEPTH];
  logic [AW-1:0]          wptr_q, scan_q, rd_addr_q;
  logic [FW-1:0]          fill_q;
  logic                   rd_vld_q;
  logic [SAMPLE_BITS-1:0] rd_data_q, entry;
  logic [SAMPLE_BITS-1:0] x_q, lo_q, hi_q, den_q;
  logic [PW-1:0]          prod_q;
  logic                   present_q, flat_q;
  logic [COLOR_W-1:0]     hue_q;
  logic [THR_W-1:0]       thr;
  logic [QUOT_W-1:0]      quot;
  logic                   div_last;
  logic                   out_valid_q;
  result_t                result_q;

  // window ring, one write at accept and one read per scan cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem[wptr_q] <= sample_i;
    end
    if (cmd_i.scan_rd) begin
      rd_data_q <= mem[scan_q];
      rd_addr_q <= scan_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q   <= '0;
      fill_q   <= '0;
      scan_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.load) begin
        wptr_q <= (wptr_q == LAST_ADDR) ? '0 : wptr_q + AW'(1);
        if (fill_q != FULL) begin
          fill_q <= fill_q + FW'(1);
        end
        scan_q <= '0;
      end else if (cmd_i.scan_rd) begin
        scan_q <= scan_q + AW'(1);
      end
    end
  end

  // entries never written read as zero, masked by the fill count
  assign entry = (FW'(rd_addr_q) < fill_q) ? rd_data_q : '0;
  assign thr   = THR_W'(cfg_i.baseline) + THR_W'(cfg_i.margin);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q  <= sample_i;
      lo_q <= sample_i;
      hi_q <= sample_i;
    end else if (rd_vld_q) begin
      if (entry < lo_q) begin
        lo_q <= entry;
      end
      if (entry > hi_q) begin
        hi_q <= entry;
      end
    end
    if (cmd_i.mul) begin
      prod_q    <= PW'(x_q - lo_q) * PW'(BAR_LENGTH);
      den_q     <= hi_q - lo_q;
      flat_q    <= hi_q == lo_q;
      present_q <= TW'(x_q) > TW'(thr);
      hue_q     <= cfg_i.hue_from_sample ? mod255(x_q) : cfg_i.fixed_hue;
    end
    if (cmd_i.out_load) begin
      result_q.lit_count  <= (present_q && !flat_q) ? quot[LIT_W-1:0] : '0;
      result_q.present    <= present_q;
      result_q.hue        <= hue_q;
      result_q.saturation <= cfg_i.saturation;
      result_q.brightness <= cfg_i.brightness;
    end
  end

  arblm_div #(
    .NUM_W(PW),
    .DEN_W(SAMPLE_BITS)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .init_i(cmd_i.div_ld),
    .step_i(cmd_i.div_step),
    .num_i (prod_q),
    .den_i (den_q),
    .quot_o(quot),
    .last_o(div_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.scan_last = scan_q == LAST_ADDR;
  assign sts_o.div_last  = div_last;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign result_o        = result_q;

endmodule

[sv/arblm_ctrl.sv]
module arblm_ctrl import arblm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read word merges into min and max
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV_LD;
      end
      ST_DIV_LD: begin
        cmd_o.div_ld = 1'b1;
        state_d      = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/auto_ranging_bar_level_meter.sv]
// auto-ranging bar level meter
// input stream s_axis: one sensor sample per transaction, in the low bits of tdata
// output stream m_axis: one result transaction per sample with segment count,
//   presence flag, hue, saturation and brightness
// config port: cfg_we_i writes register cfg_index_i with cfg_wdata_i,
//   indexes past the last register are ignored; write only while the block is idle
// each sample enters a ring of WINDOW_DEPTH entries; the window minimum and maximum
//   are found by walking the ring through its single read port, one entry a cycle,
//   then (sample - min) * BAR_LENGTH is divided by (max - min) one quotient bit a step
// the next sample is accepted only after the window scan and the 8-step divider for
//   the last one have finished and its result has been loaded into the output register
// reset: window reads as all zero (a fill count masks unwritten ring entries),
//   configuration registers take their reset values, no result is pending
// stall: a finished result waits in the output register while the next sample is
//   accepted and worked on; the controller holds the following result until the
//   output register is taken
module auto_ranging_bar_level_meter import arblm_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 24,
  parameter int unsigned BAR_LENGTH   = 12,
  parameter int unsigned SAMPLE_BITS  = 18
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // fields from bit 0: ir_sample
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
  // output stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // fields from bit 0: lit_count[3:0], present[4], hue[12:5], saturation[20:13],
  // brightness[28:21], zero fill[31:29]
  output logic [OUT_DATA_W-1:0]                 m_axis_tdata,
  // configuration write port
  input  logic                                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                  cfg_index_i,
  input  logic [CFG_W-1:0]                      cfg_wdata_i
);

  cfg_t    cfg_q;
  dp_cmd_t cmd;
  dp_sts_t sts;
  result_t result;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.baseline        <= RST_BASELINE;
      cfg_q.margin          <= RST_MARGIN;
      cfg_q.hue_from_sample <= RST_HUE_SRC;
      cfg_q.fixed_hue       <= RST_FIXED_HUE;
      cfg_q.saturation      <= RST_SATURATION;
      cfg_q.brightness      <= RST_BRIGHTNESS;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_BASELINE:   cfg_q.baseline        <= cfg_wdata_i;
        CFG_MARGIN:     cfg_q.margin          <= cfg_wdata_i;
        CFG_HUE_SRC:    cfg_q.hue_from_sample <= cfg_wdata_i[0];
        CFG_FIXED_HUE:  cfg_q.fixed_hue       <= cfg_wdata_i[COLOR_W-1:0];
        CFG_SATURATION: cfg_q.saturation      <= cfg_wdata_i[COLOR_W-1:0];
        CFG_BRIGHTNESS: cfg_q.brightness      <= cfg_wdata_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: accept, scan, multiply, divide, hand off
  arblm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // window ring, min and max, scaling and output register
  arblm_datapath #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .BAR_LENGTH  (BAR_LENGTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_i      (cfg_q),
    .sample_i   (s_axis_tdata[SAMPLE_BITS-1:0]),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .result_o   (result)
  );

  // result fields packed from the low end
  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, result.brightness, result.saturation,
                         result.hue, result.present, result.lit_count};

endmodule

[dv/auto_ranging_bar_level_meter_tb.sv]
module auto_ranging_bar_level_meter_tb;
  import arblm_pkg::*;

  // block configuration under test, kept equal to the defaults of the block
  localparam int unsigned WIN_DEPTH = 24;
  localparam int unsigned BAR_SEGS  = 12;
  localparam int unsigned SAMPLE_W  = 18;
  localparam int unsigned IN_W      = ((SAMPLE_W + 7) / 8) * 8;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

  // expected delay from an input transaction to its result
  localparam int unsigned LATENCY      = WIN_DEPTH + 13;
  localparam int unsigned DRAIN_CYCLES = 2 * LATENCY;
  // long receiver hold-off, enough for the block to back up into its input
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASE_ITEMS  = 90;
  // about ten times the slowest legal run
  localparam int unsigned TIMEOUT      = 3_000_000;

  // register indexes past the end of the register list, writes are dropped
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  // shapes of random sample runs
  typedef enum int unsigned {
    PAT_NOISE,
    PAT_BAND,
    PAT_FLAT,
    PAT_EDGE
  } sample_pat_e;

  // one row of the directed table, has_want marks a hand-typed result
  typedef struct {
    logic [IN_W-1:0] word;
    bit              has_want;
    result_t         want;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // fields from bit 0: ir_sample[17:0], unused[23:18]
  logic [IN_W-1:0]       s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // fields from bit 0: lit_count[3:0], present[4], hue[12:5], saturation[20:13],
  // brightness[28:21], zero fill[31:29]
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_W-1:0]      cfg_wdata_i;

  // mirror of the block: registers and the sample window
  cfg_t                  cfg_model;
  logic [SAMPLE_W-1:0]   window_model [WIN_DEPTH];
  // bars predicted for accepted samples, oldest first
  result_t               pending_bars [$];
  int unsigned           mismatch_cnt;
  bit                    idle_on;
  bit                    hold_rx;

  // directed rows: fresh window and reset registers
  dir_row_t directed_rows [14] = '{
    // flat all-zero window, not present, hue of zero
    '{word: 24'd0, has_want: 1'b1,
      want: '{brightness: 8'd60, saturation: 8'd220, hue: 8'd0, present: 1'b0,
              lit_count: 4'd0}},
    // full scale sample against the zeros, full bar, hue wraps to 3
    '{word: 24'h03FFFF, has_want: 1'b1,
      want: '{brightness: 8'd60, saturation: 8'd220, hue: 8'd3, present: 1'b1,
              lit_count: 4'd12}},
    // exactly on the threshold is still absent
    '{word: 24'd120, has_want: 1'b1,
      want: '{brightness: 8'd60, saturation: 8'd220, hue: 8'd120, present: 1'b0,
              lit_count: 4'd0}},
    // one above the threshold
    '{word: 24'd121, has_want: 1'b1,
      want: '{brightness: 8'd60, saturation: 8'd220, hue: 8'd121, present: 1'b1,
              lit_count: 4'd0}},
    // hue wraps at the modulus
    '{word: 24'd255, has_want: 1'b1,
      want: '{brightness: 8'd60, saturation: 8'd220, hue: 8'd0, present: 1'b1,
              lit_count: 4'd0}},
    '{word: 24'd254, has_want: 1'b1,
      want: '{brightness: 8'd60, saturation: 8'd220, hue: 8'd254, present: 1'b1,
              lit_count: 4'd0}},
    '{word: 24'd131072, has_want: 1'b0, want: '0},
    // junk above the sample bits must be masked
    '{word: {6'h3F, 18'd200000}, has_want: 1'b0, want: '0},
    '{word: {6'h2A, 18'h3FFFF}, has_want: 1'b0, want: '0},
    '{word: 24'h02AAAA, has_want: 1'b0, want: '0},
    '{word: 24'h015555, has_want: 1'b0, want: '0},
    '{word: 24'h03FFFE, has_want: 1'b0, want: '0},
    '{word: 24'd1, has_want: 1'b0, want: '0},
    '{word: {6'h15, 18'd0}, has_want: 1'b0, want: '0}
  };

  auto_ranging_bar_level_meter #(
    .WINDOW_DEPTH(WIN_DEPTH),
    .BAR_LENGTH  (BAR_SEGS),
    .SAMPLE_BITS (SAMPLE_W)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT);
    $display("auto_ranging_bar_level_meter_tb: done, errors");
    $finish;
  end

  // shift a sample into the window copy and work out the bar it gives
  function automatic result_t predict_bar(logic [IN_W-1:0] word);
    logic [SAMPLE_W-1:0] x;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W:0]   thr;
    logic [63:0]         num;
    logic [63:0]         den;
    result_t             r;
    x = word[SAMPLE_W-1:0];
    for (int i = 0; i < WIN_DEPTH - 1; i++) window_model[i] = window_model[i + 1];
    window_model[WIN_DEPTH-1] = x;
    lo = window_model[0];
    hi = window_model[0];
    for (int i = 1; i < WIN_DEPTH; i++) begin
      if (window_model[i] < lo) lo = window_model[i];
      if (window_model[i] > hi) hi = window_model[i];
    end
    // threshold sum carries into an extra bit, no wrap
    thr = {1'b0, cfg_model.baseline} + {1'b0, cfg_model.margin};
    r = '0;
    r.present = ({1'b0, x} > thr);
    // flat window gives an empty bar
    if (r.present && hi > lo) begin
      num = (64'(x) - 64'(lo)) * 64'(BAR_SEGS);
      den = 64'(hi) - 64'(lo);
      r.lit_count = LIT_W'(num / den);
    end
    r.hue        = cfg_model.hue_from_sample ? COLOR_W'(x % HUE_MOD) : cfg_model.fixed_hue;
    r.saturation = cfg_model.saturation;
    r.brightness = cfg_model.brightness;
    return r;
  endfunction

  task automatic note_field(string name, int unsigned want, int unsigned seen);
    if (want != seen) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("bar mismatch on %s: expected %0d, got %0d", name, want, seen);
    end
  endtask

  task automatic check_bar(logic [OUT_DATA_W-1:0] raw);
    result_t got;
    result_t want;
    got = result_t'(raw[$bits(result_t)-1:0]);
    if (pending_bars.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) $display("unexpected bar transaction: %h", raw);
    end else begin
      want = pending_bars.pop_front();
      note_field("lit_count", 32'(want.lit_count), 32'(got.lit_count));
      note_field("present", 32'(want.present), 32'(got.present));
      note_field("hue", 32'(want.hue), 32'(got.hue));
      note_field("saturation", 32'(want.saturation), 32'(got.saturation));
      note_field("brightness", 32'(want.brightness), 32'(got.brightness));
      note_field("zero fill", 32'd0, 32'(raw[OUT_DATA_W-1:$bits(result_t)]));
    end
  endtask

  // result checker, sees values from just before the edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_bar(m_axis_tdata);
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_rx = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // one sample transaction, optionally after a gap; valid stays high between
  // back-to-back samples
  task automatic send_sample(logic [IN_W-1:0] word, bit has_want, result_t want);
    result_t bar;
    if (idle_on && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    bar = predict_bar(word);
    pending_bars.push_back(has_want ? want : bar);
  endtask

  // stop offering samples and wait until every predicted bar has been seen
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_bars.size() != 0);
  endtask

  // single register write; caller lowers the write enable after a burst
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_BASELINE:   cfg_model.baseline        = val;
      CFG_MARGIN:     cfg_model.margin          = val;
      CFG_HUE_SRC:    cfg_model.hue_from_sample = val[0];
      CFG_FIXED_HUE:  cfg_model.fixed_hue       = val[COLOR_W-1:0];
      CFG_SATURATION: cfg_model.saturation      = val[COLOR_W-1:0];
      CFG_BRIGHTNESS: cfg_model.brightness      = val[COLOR_W-1:0];
      default: ;
    endcase
  endtask

  // write every register, junk in the bits above each narrow register, then
  // hit the spare indexes, which must not disturb anything
  task automatic program_phase(cfg_t c);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom);
    wait_drained();
    repeat (2) @(posedge clk_i);
    write_reg(CFG_BASELINE, c.baseline);
    write_reg(CFG_MARGIN, c.margin);
    write_reg(CFG_HUE_SRC, {junk[CFG_W-1:1], c.hue_from_sample});
    write_reg(CFG_FIXED_HUE, {junk[CFG_W-1:COLOR_W], c.fixed_hue});
    write_reg(CFG_SATURATION, {~junk[CFG_W-1:COLOR_W], c.saturation});
    write_reg(CFG_BRIGHTNESS, {junk[CFG_W-1:COLOR_W], c.brightness});
    write_reg(IDX_SPARE_LO, CFG_W'($urandom));
    write_reg(IDX_SPARE_HI, CFG_W'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // random runs: noise, narrow bands, flat stretches longer than the window,
  // and values at the range ends and around the presence threshold
  task automatic run_phase(int unsigned n_items, bit do_hold, bit do_pause);
    int unsigned         left;
    int unsigned         len;
    sample_pat_e         pat;
    logic [SAMPLE_W-1:0] center;
    logic [SAMPLE_W-1:0] span_mask;
    logic [SAMPLE_W-1:0] x;
    logic [SAMPLE_W:0]   thr;
    logic [5:0]          pad;
    left = n_items;
    while (left > 0) begin
      pat       = sample_pat_e'($urandom_range(0, 3));
      center    = SAMPLE_W'($urandom);
      span_mask = SAMPLE_W'((1 << $urandom_range(0, SAMPLE_W - 1)) - 1);
      len       = (pat == PAT_FLAT) ? $urandom_range(WIN_DEPTH + 1, WIN_DEPTH + 6)
                                    : $urandom_range(4, 30);
      if (len > left) len = left;
      repeat (len) begin
        thr = {1'b0, cfg_model.baseline} + {1'b0, cfg_model.margin};
        case (pat)
          PAT_NOISE: x = SAMPLE_W'($urandom);
          PAT_BAND:  x = center ^ (SAMPLE_W'($urandom) & span_mask);
          PAT_FLAT:  x = center;
          default: begin
            case ($urandom_range(0, 3))
              0: x = '0;
              1: x = SAMPLE_MAX;
              2: x = (thr > SAMPLE_MAX) ? SAMPLE_MAX : thr[SAMPLE_W-1:0];
              default: x = (thr >= SAMPLE_MAX) ? SAMPLE_MAX : thr[SAMPLE_W-1:0] + 1'b1;
            endcase
          end
        endcase
        pad = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'd0;
        // midway: back up the block, or let it run dry
        if (left == n_items / 2) begin
          if (do_hold) hold_rx = 1'b1;
          if (do_pause) wait_drained();
        end
        send_sample({pad, x}, 1'b0, '0);
        left--;
      end
    end
  endtask

  // main sequence
  initial begin
    cfg_t phase_cfg;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= '0;
    cfg_wdata_i   <= '0;
    mismatch_cnt  = 0;
    idle_on       = 1'b1;
    hold_rx       = 1'b0;
    cfg_model     = '{baseline: RST_BASELINE, margin: RST_MARGIN,
                      hue_from_sample: RST_HUE_SRC, fixed_hue: RST_FIXED_HUE,
                      saturation: RST_SATURATION, brightness: RST_BRIGHTNESS};
    for (int i = 0; i < WIN_DEPTH; i++) window_model[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed table on reset registers
    foreach (directed_rows[i])
      send_sample(directed_rows[i].word, directed_rows[i].has_want, directed_rows[i].want);

    // everything at zero: threshold zero, saturation and brightness zero, hue from the sample
    phase_cfg = '{baseline: '0, margin: '0, hue_from_sample: 1'b1, fixed_hue: '0,
                  saturation: '0, brightness: '0};
    program_phase(phase_cfg);
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);

    // everything at full scale: threshold above any sample, fixed hue
    phase_cfg = '{baseline: SAMPLE_MAX, margin: SAMPLE_MAX, hue_from_sample: 1'b0,
                  fixed_hue: 8'hFF, saturation: 8'hFF, brightness: 8'hFF};
    program_phase(phase_cfg);
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);

    // random mid-range threshold, receiver hold-off in the middle
    phase_cfg = '{baseline: CFG_W'($urandom_range(0, 1 << 17)),
                  margin: CFG_W'($urandom_range(0, 4000)), hue_from_sample: 1'b1,
                  fixed_hue: COLOR_W'($urandom), saturation: COLOR_W'($urandom),
                  brightness: COLOR_W'($urandom)};
    program_phase(phase_cfg);
    run_phase(PHASE_ITEMS, 1'b1, 1'b0);

    // zero margin, fixed hue, sender pause in the middle
    phase_cfg = '{baseline: CFG_W'(100000), margin: '0, hue_from_sample: 1'b0,
                  fixed_hue: COLOR_W'($urandom), saturation: COLOR_W'($urandom),
                  brightness: COLOR_W'($urandom)};
    program_phase(phase_cfg);
    run_phase(PHASE_ITEMS, 1'b0, 1'b1);

    // back to the reset values
    phase_cfg = '{baseline: RST_BASELINE, margin: RST_MARGIN,
                  hue_from_sample: RST_HUE_SRC, fixed_hue: RST_FIXED_HUE,
                  saturation: RST_SATURATION, brightness: RST_BRIGHTNESS};
    program_phase(phase_cfg);
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);

    // last stretch at full rate, no idling on either side
    phase_cfg = '{baseline: CFG_W'($urandom_range(0, 5000)),
                  margin: CFG_W'($urandom_range(0, 255)), hue_from_sample: 1'b1,
                  fixed_hue: COLOR_W'($urandom), saturation: COLOR_W'($urandom),
                  brightness: COLOR_W'($urandom)};
    program_phase(phase_cfg);
    idle_on = 1'b0;
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("auto_ranging_bar_level_meter_tb: done, clean");
    end else begin
      $display("auto_ranging_bar_level_meter_tb: done, errors");
    end
    $finish;
  end

endmodule
